>>> rtl/horizontal_box_blur_rgb_macros.svh
// Assertion macros used by the horizontal box blur top level.
`ifndef HORIZONTAL_BOX_BLUR_RGB_MACROS_SVH
`define HORIZONTAL_BOX_BLUR_RGB_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define HBB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hbb: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define HBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hbb: next-cycle check failed");
`else
`define HBB_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define HBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/hbb_pkg.sv
// Types, constants and codes shared by the horizontal box blur modules.
package hbb_pkg;

	localparam int PIX_W      = 8;
	localparam int MAX_RADIUS = 15;
	localparam int MAX_WIDTH  = 4096;

	// Register field widths
	localparam int RAD_W   = 4;
	localparam int ROWW_W  = 13;
	localparam int RECIP_W = 17;
	localparam int CFG_W   = 17;
	localparam int CFG_IDX_W = 2;

	// Derived widths
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int W_W       = COL_W + 1;
	localparam int WIN_DEPTH = 1 << $clog2(2 * MAX_RADIUS + 2);
	localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
	localparam int SUM_W     = 13;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = SUM_W + RECIP_W;

	localparam logic [RAD_W-1:0]   RADIUS_RST    = RAD_W'(1);
	localparam logic [ROWW_W-1:0]  ROW_WIDTH_RST = ROWW_W'(640);
	localparam logic [RECIP_W-1:0] RECIP_RST     = RECIP_W'(21845);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS    = 2'd0,
		REG_ROW_WIDTH = 2'd1,
		REG_RECIP     = 2'd2
	} hbb_reg_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic take;    // capture pixel, read drop entry
		logic slide;   // update sums for the new pixel, store it
		logic fslide;  // update sums for one flushed column
		logic mul;     // scale sums by the reciprocal
		logic load;    // load the output register
		logic step;    // advance flush column, read its drop entry
	} hbb_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic emit_pix;    // current pixel produces a result
		logic flush_more;  // row-end flush has columns left
	} hbb_stat_t;

endpackage

>>> rtl/hbb_stream_if.sv
// Valid/ready stream interfaces for the pixel input and the blurred output.
interface hbb_pix_if import hbb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_in;
	logic [PIX_W-1:0] green_in;
	logic [PIX_W-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface hbb_res_if import hbb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_out;
	logic [PIX_W-1:0] green_out;
	logic [PIX_W-1:0] blue_out;
	logic [COL_W-1:0] out_column;
	logic             row_end;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output out_column, output row_end, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input out_column, input row_end, output ready);
endinterface

>>> rtl/horizontal_box_blur_rgb.sv
// Top level of the horizontal RGB box blur with edge replication.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+------------------------------------------
//  pixel    | in  | valid / ready        | red_in, green_in, blue_in
//  result   | out | valid / ready        | red_out, green_out, blue_out, out_column, row_end
//  cfg      | in  | cfg_write (no stall) | cfg_index, cfg_data
//
// A pixel that yields no result (the first r pixels of a row) passes through capture and
// sum update; a pixel that yields one also passes through reciprocal multiply and output
// load. The row's last pixel then runs each of its r flushed columns through the same
// sum/multiply/load sequence, driven by the sequential controller with its registered
// window read and its registered sum and multiply stages. A beat left waiting in the
// output register does not block the next pixel; only the next output load waits for it.
// Reset restores the register defaults and starts a new row; the window memory needs no
// clearing.
`include "horizontal_box_blur_rgb_macros.svh"
module horizontal_box_blur_rgb import hbb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	hbb_pix_if.sink              pixel,
	hbb_res_if.source            result,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	hbb_cmd_t  cmd;
	hbb_stat_t stat;

	// Sequencer: owns the handshakes and the output valid flag
	hbb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: config, window, sums, scaling and the output register
	hbb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.red_in     (pixel.red_in),
		.green_in   (pixel.green_in),
		.blue_in    (pixel.blue_in),
		.cmd        (cmd),
		.stat       (stat),
		.red_out    (result.red_out),
		.green_out  (result.green_out),
		.blue_out   (result.blue_out),
		.out_column (result.out_column),
		.row_end    (result.row_end)
	);

	// An accepted pixel always updates the sums on the following cycle
	`HBB_ASSERT_NEXT(a_take_then_slide, clk, arst_n, pixel.valid && pixel.ready, cmd.slide)
	// Never overwrite a beat that has not been taken
	`HBB_ASSERT_SAME(a_load_room, clk, arst_n, cmd.load, !result.valid || result.ready)
	// A multiply is followed by the output stage, never by a new capture
	`HBB_ASSERT_NEXT(a_mul_blocks_input, clk, arst_n, cmd.mul, !pixel.ready)
	// Sum updates come only from a capture or a flush step in the previous cycle
	`HBB_ASSERT_SAME(a_slide_source, clk, arst_n, cmd.slide || cmd.fslide, $past(cmd.take) || $past(cmd.step))

endmodule

>>> rtl/hbb_ctrl.sv
// Sequencing state machine of the box blur: one pixel at a time, then the row-end flush.
module hbb_ctrl import hbb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  hbb_stat_t stat,
	output hbb_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SLIDE  = 5'b00010,
		S_MUL    = 5'b00100,
		S_EMIT   = 5'b01000,
		S_FSLIDE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_SLIDE;
				end
			end
			S_SLIDE: begin
				cmd.slide = 1'b1;
				state_d   = stat.emit_pix ? S_MUL : S_IDLE;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				// hold until the output register has room
				if (out_free) begin
					cmd.load = 1'b1;
					if (stat.flush_more) begin
						cmd.step = 1'b1;
						state_d  = S_FSLIDE;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_FSLIDE: begin
				cmd.fslide = 1'b1;
				state_d    = S_MUL;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/hbb_dp.sv
// Box blur datapath: config registers, window memory, running sums, scaling, output register.
module hbb_dp import hbb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [PIX_W-1:0]     red_in,
	input  logic [PIX_W-1:0]     green_in,
	input  logic [PIX_W-1:0]     blue_in,
	input  hbb_cmd_t             cmd,
	output hbb_stat_t            stat,
	output logic [PIX_W-1:0]     red_out,
	output logic [PIX_W-1:0]     green_out,
	output logic [PIX_W-1:0]     blue_out,
	output logic [COL_W-1:0]     out_column,
	output logic                 row_end
);

	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

	function automatic logic [PIX_W-1:0] sat_mean(input logic [PROD_W-1:0] p);
		logic [PIX_W-1:0] m;
		if (p[PROD_W-1:FRAC_W+PIX_W] != '0) begin
			m = '1;
		end else begin
			m = p[FRAC_W+PIX_W-1:FRAC_W];
		end
		return m;
	endfunction

	logic [RAD_W-1:0]   radius_q;
	logic [ROWW_W-1:0]  row_width_q;
	logic [RECIP_W-1:0] recip_q;
	logic [COL_W-1:0]   col_q;
	logic               row_last_q;

	logic [2:0][PIX_W-1:0] pix_q;
	logic [2:0][PIX_W-1:0] first_q;
	logic [2:0][PIX_W-1:0] rd_q;
	logic [2:0][PIX_W-1:0] win_mem [WIN_DEPTH];
	logic [COL_W-1:0]      k_q;
	logic [COL_W-1:0]      ocol_q;
	logic [SUM_W-1:0]      sum_q  [3];
	logic [PROD_W-1:0]     prod_q [3];

	logic [W_W-1:0]       eff_w;
	logic [W_W-1:0]       w_last;
	logic [W_W-1:0]       half_w;
	logic [RAD_W-1:0]     rad_cl;
	logic [RAD_W-1:0]     rad;
	logic [RAD_W:0]       span;
	logic [COL_W-1:0]     rdiff;
	logic [WIN_IDX_W-1:0] raddr;
	logic [2:0][PIX_W-1:0] drop;
	logic                 k_is_last;

	// Effective width and radius
	always_comb begin
		if (row_width_q == '0) begin
			eff_w = W_W'(1);
		end else if (W_W'(row_width_q) > W_W'(MAX_WIDTH) || row_width_q > ROWW_W'(MAX_WIDTH)) begin
			eff_w = W_W'(MAX_WIDTH);
		end else begin
			eff_w = W_W'(row_width_q);
		end
		w_last = eff_w - W_W'(1);
		half_w = w_last >> 1;
		rad_cl = (radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q;
		rad    = (W_W'(rad_cl) > half_w) ? RAD_W'(half_w) : rad_cl;
		span   = {rad, 1'b1};
	end

	assign k_is_last = (W_W'(k_q) == w_last);

	assign stat.emit_pix   = (k_q >= COL_W'(rad));
	assign stat.flush_more = row_last_q && (W_W'(ocol_q) != w_last);

	// Drop entry address: k-2r-1 on capture, c-r-1 for the next flush column
	assign rdiff = cmd.take ? (col_q - COL_W'(span)) : (ocol_q - COL_W'(rad));
	assign raddr = rdiff[WIN_IDX_W-1:0];

	// Oldest pixel leaving the window; the row's first pixel stands in left of column 0
	always_comb begin
		if (cmd.fslide) begin
			drop = (ocol_q > COL_W'(rad)) ? rd_q : first_q;
		end else begin
			drop = (k_q > COL_W'({rad, 1'b0})) ? rd_q : first_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= RADIUS_RST;
			row_width_q <= ROW_WIDTH_RST;
			recip_q     <= RECIP_RST;
			col_q       <= '0;
			row_last_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_RADIUS: begin
						radius_q <= cfg_data[RAD_W-1:0];
						col_q    <= '0;
					end
					REG_ROW_WIDTH: begin
						row_width_q <= cfg_data[ROWW_W-1:0];
						col_q       <= '0;
					end
					REG_RECIP: begin
						recip_q <= cfg_data[RECIP_W-1:0];
						col_q   <= '0;
					end
					default: ;
				endcase
			end else if (cmd.slide) begin
				row_last_q <= k_is_last;
				col_q      <= k_is_last ? '0 : k_q + COL_W'(1);
			end
		end
	end

	// Window memory: one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.slide) begin
			win_mem[k_q[WIN_IDX_W-1:0]] <= pix_q;
		end
		if (cmd.take || cmd.step) begin
			rd_q <= win_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pix_q <= {red_in, green_in, blue_in};
			k_q   <= col_q;
		end
		if (cmd.slide) begin
			ocol_q <= k_q - COL_W'(rad);
			if (k_q == '0) begin
				first_q <= pix_q;
			end
		end
		if (cmd.step) begin
			ocol_q <= ocol_q + COL_W'(1);
		end
		for (int i = 0; i < 3; i++) begin
			if (cmd.slide && k_q == '0) begin
				sum_q[i] <= SUM_W'(pix_q[i]) * SUM_W'(span);
			end else if (cmd.slide || cmd.fslide) begin
				sum_q[i] <= sum_q[i] + SUM_W'(pix_q[i]) - SUM_W'(drop[i]);
			end
			if (cmd.mul) begin
				prod_q[i] <= PROD_W'(sum_q[i]) * PROD_W'(recip_q) + ROUND_HALF;
			end
		end
		if (cmd.load) begin
			red_out    <= sat_mean(prod_q[2]);
			green_out  <= sat_mean(prod_q[1]);
			blue_out   <= sat_mean(prod_q[0]);
			out_column <= ocol_q;
			row_end    <= row_last_q && (W_W'(ocol_q) == w_last);
		end
	end

endmodule

>>> verif/horizontal_box_blur_rgb_tb.sv
// Self-checking testbench for the horizontal RGB box blur: directed table, then random phases.
module horizontal_box_blur_rgb_tb;
	import hbb_pkg::*;

	localparam int PERIOD   = 4;
	localparam int RING     = 2 * MAX_RADIUS + 2;  // column-indexed window ring depth
	localparam int SETTLE   = 10;                  // cycles for a pixel that emits nothing
	localparam int DRAIN    = 100;                 // cycles to wait out after the last beat
	localparam int RANDOM_ITEMS = 192;             // the directed table adds 16 pixels
	localparam int LIMIT    = 2_000_000;           // time units before the run is abandoned

	// The index field has one code past the last register; writes there are ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;
	typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_BEAT} check_kind_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [COL_W-1:0] column;
		logic             last;
	} blur_beat_t;

	typedef struct packed {
		step_kind_t             kind;
		logic [CFG_IDX_W-1:0]   index;
		logic [3*PIX_W-1:0]     value;  // pixel R,G,B or register data
		check_kind_t            check;
		blur_beat_t             beat;   // typed expectation for CHECK_BEAT rows
	} plan_row_t;

	// Directed table. Typed beats only where the answer is obvious: a one-pixel row with
	// radius zero makes the output equal to the pixel scaled by the reciprocal.
	localparam plan_row_t PLAN [28] = '{
		// after reset: radius 1, width 640, so column 0 emits nothing
		'{STEP_PIXEL, '0, 24'h123456, CHECK_NONE, '0},
		'{STEP_PIXEL, '0, 24'hABCDEF, CHECK_MODEL, '0},
		// unused index must not abandon the row
		'{STEP_WRITE, REG_UNUSED, 24'h01FFFF, CHECK_MODEL, '0},
		'{STEP_PIXEL, '0, 24'h000000, CHECK_MODEL, '0},
		// one-pixel rows, unit reciprocal: pass-through
		'{STEP_WRITE, REG_RADIUS, 24'd0, CHECK_MODEL, '0},
		'{STEP_WRITE, REG_ROW_WIDTH, 24'd1, CHECK_MODEL, '0},
		'{STEP_WRITE, REG_RECIP, 24'h010000, CHECK_MODEL, '0},
		'{STEP_PIXEL, '0, 24'hFFFFFF, CHECK_BEAT, '{8'd255, 8'd255, 8'd255, 12'd0, 1'b1}},
		'{STEP_PIXEL, '0, 24'h000000, CHECK_BEAT, '{8'd0, 8'd0, 8'd0, 12'd0, 1'b1}},
		'{STEP_PIXEL, '0, 24'h01FF80, CHECK_BEAT, '{8'd1, 8'd255, 8'd128, 12'd0, 1'b1}},
		// zero reciprocal forces all means to zero
		'{STEP_WRITE, REG_RECIP, 24'd0, CHECK_MODEL, '0},
		'{STEP_PIXEL, '0, 24'hFFFFFF, CHECK_BEAT, '{8'd0, 8'd0, 8'd0, 12'd0, 1'b1}},
		// reciprocal near 2.0: mid values saturate
		'{STEP_WRITE, REG_RECIP, 24'h01FFFF, CHECK_MODEL, '0},
		'{STEP_PIXEL, '0, 24'h800100, CHECK_BEAT, '{8'd255, 8'd2, 8'd0, 12'd0, 1'b1}},
		// width zero behaves as one
		'{STEP_WRITE, REG_ROW_WIDTH, 24'd0, CHECK_MODEL, '0},
		'{STEP_WRITE, REG_RECIP, 24'd21845, CHECK_MODEL, '0},
		'{STEP_PIXEL, '0, 24'h00FF00, CHECK_MODEL, '0},
		// all-ones data: radius 15, width 8191 clamped to the maximum
		'{STEP_WRITE, REG_RADIUS, 24'h01FFFF, CHECK_MODEL, '0},
		'{STEP_WRITE, REG_ROW_WIDTH, 24'h01FFFF, CHECK_MODEL, '0},
		'{STEP_PIXEL, '0, 24'hFFFFFF, CHECK_MODEL, '0},
		'{STEP_PIXEL, '0, 24'h7F7F7F, CHECK_MODEL, '0},
		// radius clamped by a width of five down to two
		'{STEP_WRITE, REG_ROW_WIDTH, 24'd5, CHECK_MODEL, '0},
		'{STEP_WRITE, REG_RECIP, 24'd13107, CHECK_MODEL, '0},
		'{STEP_PIXEL, '0, 24'hFFFFFF, CHECK_MODEL, '0},
		'{STEP_PIXEL, '0, 24'h000000, CHECK_MODEL, '0},
		'{STEP_PIXEL, '0, 24'hFFFFFF, CHECK_MODEL, '0},
		'{STEP_PIXEL, '0, 24'h000000, CHECK_MODEL, '0},
		'{STEP_PIXEL, '0, 24'hFFFFFF, CHECK_MODEL, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	hbb_pix_if pix ();
	hbb_res_if res ();

	horizontal_box_blur_rgb DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pix),
		.result    (res),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Predictor copy of the registers and the row state.
	logic [RAD_W-1:0]   radius_q = RADIUS_RST;
	logic [ROWW_W-1:0]  width_q  = ROW_WIDTH_RST;
	logic [RECIP_W-1:0] recip_q  = RECIP_RST;
	logic [3*PIX_W-1:0] window_q [RING];
	logic [SUM_W-1:0]   red_acc   = '0;
	logic [SUM_W-1:0]   green_acc = '0;
	logic [SUM_W-1:0]   blue_acc  = '0;
	logic [3*PIX_W-1:0] row_head  = '0;
	int unsigned        next_col  = 0;

	blur_beat_t pending_beats [$];  // expected output beats, oldest first
	int  fail_count = 0;
	int  sink_wait  = 0;
	bit  src_calm   = 1'b0;  // no gaps before input beats this phase
	bit  sink_calm  = 1'b0;  // no stalls on the output this phase
	bit  dirty      = 1'b0;  // pixels sent since the block was last seen idle

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	function automatic void restart_row();
		red_acc   = '0;
		green_acc = '0;
		blue_acc  = '0;
		next_col  = 0;
	endfunction

	function automatic logic [PIX_W-1:0] scaled_mean(input logic [SUM_W-1:0] s);
		longint unsigned v;
		v = (64'(s) * 64'(recip_q) + 64'd32768) >> FRAC_W;
		return (v > 64'd255) ? 8'd255 : v[PIX_W-1:0];
	endfunction

	function automatic void slide_window(input logic [3*PIX_W-1:0] add, drop);
		red_acc   = red_acc   + add[23:16] - drop[23:16];
		green_acc = green_acc + add[15:8]  - drop[15:8];
		blue_acc  = blue_acc  + add[7:0]   - drop[7:0];
	endfunction

	function automatic void emit_beat(input int unsigned col, input bit last, input bit keep);
		blur_beat_t b;
		b.red    = scaled_mean(red_acc);
		b.green  = scaled_mean(green_acc);
		b.blue   = scaled_mean(blue_acc);
		b.column = COL_W'(col);
		b.last   = last;
		if (keep)
			pending_beats.push_back(b);
	endfunction

	// Advance the predictor by one accepted pixel; queue its beats when keep is set.
	function automatic void blur_pixel(input logic [3*PIX_W-1:0] p, input bit keep);
		int unsigned w, r, k, c, span;
		logic [3*PIX_W-1:0] drop;
		w = width_q;
		if (w == 0) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		r = radius_q;
		if (r > MAX_RADIUS) r = MAX_RADIUS;
		if (r > (w - 1) / 2) r = (w - 1) / 2;
		k = next_col;
		if (k >= w) k = w - 1;
		span = 2 * r + 1;

		// Row start: the replicated left edge fills the whole window.
		if (k == 0) begin
			row_head  = p;
			red_acc   = SUM_W'(p[23:16] * span);
			green_acc = SUM_W'(p[15:8] * span);
			blue_acc  = SUM_W'(p[7:0] * span);
		end else begin
			drop = (k >= span) ? window_q[(k - span) % RING] : row_head;
			slide_window(p, drop);
		end
		window_q[k % RING] = p;

		if (k >= r)
			emit_beat(k - r, (r == 0) && (k == w - 1), keep);

		// Row end: replicate the last pixel to flush the remaining columns.
		if (k == w - 1) begin
			for (c = w - r; c < w; c++) begin
				drop = (c >= r + 1) ? window_q[(c - r - 1) % RING] : row_head;
				slide_window(p, drop);
				emit_beat(c, c == w - 1, keep);
			end
			restart_row();
		end else begin
			next_col = (k + 1) % 4096;
		end
	endfunction

	// Hold off until every expected beat is out, then let a silent pixel finish.
	task automatic wait_idle();
		pix.valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		dirty = 1'b0;
	endtask

	// Leaves cfg_write high so that back-to-back writes keep it steady.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		if (dirty)
			wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_RADIUS: begin
				radius_q = data[RAD_W-1:0];
				restart_row();
			end
			REG_ROW_WIDTH: begin
				width_q = data[ROWW_W-1:0];
				restart_row();
			end
			REG_RECIP: begin
				recip_q = data[RECIP_W-1:0];
				restart_row();
			end
			default: ;  // ignored index, row carries on
		endcase
	endtask

	task automatic send_pixel(input logic [3*PIX_W-1:0] p, input bit keep);
		int gap;
		gap = src_calm ? 0 : $urandom_range(0, 9);
		cfg_write <= 1'b0;
		if (gap != 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid    <= 1'b1;
		pix.red_in   <= p[23:16];
		pix.green_in <= p[15:8];
		pix.blue_in  <= p[7:0];
		do @(posedge clk); while (!pix.ready);
		blur_pixel(p, keep);
		dirty = 1'b1;
	endtask

	// Output side: draw a stall per beat, check every accepted beat against the queue head.
	always @(posedge clk or negedge arst_n) begin : result_sink
		blur_beat_t got, want;
		if (!arst_n) begin
			res.ready <= 1'b0;
			sink_wait = 0;
		end else begin
			if (res.valid && res.ready) begin
				got = '{res.red_out, res.green_out, res.blue_out, res.out_column, res.row_end};
				if (pending_beats.size() == 0) begin
					note_failure($sformatf("unexpected beat r=%0d g=%0d b=%0d col=%0d end=%0b",
						got.red, got.green, got.blue, got.column, got.last));
				end else begin
					want = pending_beats.pop_front();
					if (got.red != want.red || got.green != want.green || got.blue != want.blue
						|| got.column != want.column || got.last != want.last)
						note_failure($sformatf(
							"exp r=%0d g=%0d b=%0d col=%0d end=%0b, got r=%0d g=%0d b=%0d col=%0d end=%0b",
							want.red, want.green, want.blue, want.column, want.last,
							got.red, got.green, got.blue, got.column, got.last));
				end
				sink_wait = sink_calm ? 0 : $urandom_range(0, 9);
			end else if (sink_wait != 0) begin
				sink_wait--;
			end
			res.ready <= (sink_wait == 0);
		end
	end

	initial begin : stimulus
		int unsigned random_pixels, count, n, eff_w, eff_r, width_val, rad_val, first, j;
		logic [31:0] junk, px;
		logic [RECIP_W-1:0] recip_val;
		logic [3*PIX_W-1:0] p;
		bit bright;

		pix.valid    = 1'b0;
		pix.red_in   = '0;
		pix.green_in = '0;
		pix.blue_in  = '0;
		cfg_write    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (PLAN[i]) begin
			if (PLAN[i].kind == STEP_WRITE) begin
				write_reg(PLAN[i].index, PLAN[i].value[CFG_W-1:0]);
			end else begin
				send_pixel(PLAN[i].value, PLAN[i].check == CHECK_MODEL);
				if (PLAN[i].check == CHECK_BEAT)
					pending_beats.push_back(PLAN[i].beat);
			end
		end

		// Random phases: new setting, then mostly whole rows, sometimes a cut-off row.
		random_pixels = 0;
		while (random_pixels < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0:       rad_val = 0;
				1:       rad_val = MAX_RADIUS;
				default: rad_val = $urandom_range(0, MAX_RADIUS);
			endcase
			case ($urandom_range(0, 9))
				0:       width_val = 0;
				1:       width_val = 1;
				2:       width_val = 2;
				3:       width_val = 2 * MAX_RADIUS + 1;
				4:       width_val = $urandom_range(0, 1) ? MAX_WIDTH : $urandom_range(4097, 8191);
				default: width_val = $urandom_range(3, 40);
			endcase
			eff_w = (width_val == 0) ? 1 : ((width_val > MAX_WIDTH) ? MAX_WIDTH : width_val);
			eff_r = rad_val;
			if (eff_r > (eff_w - 1) / 2) eff_r = (eff_w - 1) / 2;
			case ($urandom_range(0, 19))
				0:       recip_val = '0;
				1:       recip_val = '1;
				2:       recip_val = 17'h10000;
				3, 4, 5: recip_val = RECIP_W'($urandom_range(0, 17'h1FFFF));
				default: recip_val = RECIP_W'((65536 + eff_r) / (2 * eff_r + 1));
			endcase

			// Write all three registers in a rotated order, junk in the unused data bits.
			first = $urandom_range(0, 2);
			for (j = 0; j < 3; j++) begin
				junk = $urandom();
				case ((first + j) % 3)
					0:       write_reg(REG_RADIUS, {junk[16:4], rad_val[3:0]});
					1:       write_reg(REG_ROW_WIDTH, {junk[16:13], width_val[12:0]});
					default: write_reg(REG_RECIP, recip_val);
				endcase
			end
			if ($urandom_range(0, 3) == 0) begin
				junk = $urandom();
				write_reg(REG_UNUSED, junk[CFG_W-1:0]);
			end

			src_calm  = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			bright    = ($urandom_range(0, 6) == 0);

			// Very wide rows only get a short start, then the next write abandons them.
			if (eff_w > 64) begin
				count = $urandom_range(8, 24);
			end else begin
				count = eff_w * $urandom_range(1, 3);
				if ($urandom_range(0, 3) == 0)
					count += $urandom_range(0, eff_w - 1);
			end

			// Stop at the item budget, even in the middle of a row.
			for (n = 0; n < count && random_pixels < RANDOM_ITEMS; n++) begin
				px = $urandom();
				case ($urandom_range(0, 9))
					0:       p = '0;
					1:       p = '1;
					default: p = bright ? {8'($urandom_range(200, 255)), 8'($urandom_range(200, 255)),
						8'($urandom_range(200, 255))} : px[23:0];
				endcase
				send_pixel(p, 1'b1);
				random_pixels++;
			end
		end

		// Drain: every expected beat out, then a quiet stretch to catch strays.
		pix.valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fail_count == 0 && pending_beats.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin : watchdog
		#(LIMIT);
		$display("FAILURE");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/hbb_pkg.sv
rtl/hbb_stream_if.sv
rtl/hbb_ctrl.sv
rtl/hbb_dp.sv
rtl/horizontal_box_blur_rgb.sv
verif/horizontal_box_blur_rgb_tb.sv
